>>> rtl/core/spq_pkg.sv
// Shared constants, codes and types of the sorted priority queue.
package spq_pkg;

   localparam int DEPTH = 64;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam int ValueWidth = 32;
   localparam int PrioWidth = 16;
   localparam int OccWidth = 7;
   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 56;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DEQUEUED  = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [PrioWidth-1:0]  prio;
      logic [ValueWidth-1:0] value;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic remove;
      logic occupied;
   } cell_ctrl_type;

endpackage

>>> rtl/core/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and shifts it left or right.
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   input  logic                  left_keep,
   output spq_pkg::entry_type    entry,
   output logic                  keep
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // The cell keeps its entry when it is held and not served later than the new one.
   assign keep = ctrl.occupied && ($signed(entry_ff.prio) <= $signed(new_entry.prio));

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         priority if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, entry count and result register.
//
// The request channel (req_) carries one operation per transaction: tuser holds the
// opcode (enqueue or dequeue), tdata the value and priority to insert. Every request
// yields exactly one response transaction on the rsp_ channel: tuser holds the status
// (inserted, dequeued, overflow, underflow), tdata the removed head value and
// priority (zero unless dequeued) and the occupancy after the operation.
// Entries sit in a row of DEPTH cells sorted by priority, lowest number at the head;
// all cells compare with the incoming priority at once and shift together, so an
// insert or a remove completes in the cycle it is accepted.
// The response appears in the cycle after the request is accepted, and a new request
// is taken in every cycle while the response register is empty or being drained,
// giving one transaction per cycle. When the receiver stalls, the response holds
// and req_tready falls until it is taken.
// Reset empties the queue and clears the response valid flag, not its status and data;
// stored entries are not cleared, as only held entries are ever read.
module sorted_priority_queue (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [spq_pkg::ReqDataWidth-1:0] req_tdata,  // item_value, item_priority
   input  logic [0:0]                       req_tuser,  // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [spq_pkg::RspDataWidth-1:0] rsp_tdata,  // head_value, head_priority,
                                                        // occupancy, zero pad
   output logic [1:0]                       rsp_tuser   // status
);

   localparam int Depth = spq_pkg::DEPTH;
   localparam int CountWidth = spq_pkg::CountWidth;

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   spq_pkg::status_type rsp_status_ff;
   spq_pkg::status_type rsp_status_in;
   logic [spq_pkg::RspDataWidth-1:0] rsp_data_ff;
   logic [spq_pkg::RspDataWidth-1:0] rsp_data_in;

   spq_pkg::entry_type new_entry;
   spq_pkg::entry_type cell_entry [Depth];
   logic [Depth-1:0] cell_keep;
   logic accept;
   logic full;
   logic empty;
   logic do_insert;
   logic do_remove;
   spq_pkg::opcode_type opcode;
   spq_pkg::entry_type head;

   assign new_entry.value = req_tdata[31:0];
   assign new_entry.prio = req_tdata[47:32];
   assign opcode = spq_pkg::opcode_type'(req_tuser);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign full = (count_ff == CountWidth'(Depth));
   assign empty = (count_ff == '0);
   assign do_insert = accept && (opcode == spq_pkg::OP_ENQUEUE) && !full;
   assign do_remove = accept && (opcode == spq_pkg::OP_DEQUEUE) && !empty;
   assign head = cell_entry[0];

   for (genvar i = 0; i < Depth; i++) begin : g_cell
      spq_pkg::cell_ctrl_type ctrl;
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic left_keep;

      assign ctrl.insert = do_insert;
      assign ctrl.remove = do_remove;
      assign ctrl.occupied = (count_ff > CountWidth'(i));

      if (i == 0) begin : g_first
         assign left_entry = new_entry;
         assign left_keep = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == Depth - 1) begin : g_last
         assign right_entry = new_entry;
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .left_keep   (left_keep),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_remove) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = '0;
         rsp_data_in[54:48] = spq_pkg::OccWidth'(count_in);
         unique case (opcode)
            spq_pkg::OP_ENQUEUE: begin
               rsp_status_in = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
            end
            spq_pkg::OP_DEQUEUE: begin
               if (empty) begin
                  rsp_status_in = spq_pkg::ST_UNDERFLOW;
               end else begin
                  rsp_status_in = spq_pkg::ST_DEQUEUED;
                  rsp_data_in[31:0] = head.value;
                  rsp_data_in[47:32] = head.prio;
               end
            end
            default: begin
               rsp_status_in = spq_pkg::ST_UNDERFLOW;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_status_ff;

endmodule

>>> rtl/core/spq_checker.sv
// Port-level checks of the sorted priority queue and their binding to the top level.
module spq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [spq_pkg::RspDataWidth-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   // A stalled response transaction holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Every accepted request yields a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no response");

   // Head fields are zero unless the head was removed.
   a_head_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != spq_pkg::ST_DEQUEUED) |-> rsp_tdata[47:0] == '0)
      else $error("head fields set without a dequeue");

   // Underflow only happens on an empty queue, overflow only on a full one.
   a_empty_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == spq_pkg::ST_UNDERFLOW && rsp_tdata[54:48] != '0) ||
      (rsp_tuser == spq_pkg::ST_OVERFLOW &&
      rsp_tdata[54:48] != spq_pkg::OccWidth'(spq_pkg::DEPTH))) |-> 1'b0)
      else $error("occupancy disagrees with status");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> tb/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the sorted priority queue, predicting every response in a scoreboard.
module sorted_priority_queue_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int IDLE_PERCENT = 29;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      spq_pkg::status_type            status;
      logic [spq_pkg::ValueWidth-1:0] value;
      logic [spq_pkg::PrioWidth-1:0]  prio;
      logic [spq_pkg::OccWidth-1:0]   occupancy;
   } queue_result_type;

   class head_order_checker;
      logic [spq_pkg::ValueWidth-1:0]       held_value[spq_pkg::DEPTH];
      logic signed [spq_pkg::PrioWidth-1:0] held_prio[spq_pkg::DEPTH];
      int                                   held_count;
      queue_result_type                     awaited_results[$];
      int                                   failures;

      function new();
         held_count = 0;
         failures = 0;
      endfunction

      function void note_request(spq_pkg::opcode_type op,
                                 logic [spq_pkg::ValueWidth-1:0] value,
                                 logic signed [spq_pkg::PrioWidth-1:0] prio);
         queue_result_type r;
         int               pos;
         r.status = spq_pkg::ST_INSERTED;
         r.value = '0;
         r.prio = '0;
         if (op == spq_pkg::OP_ENQUEUE) begin
            if (held_count >= spq_pkg::DEPTH) begin
               r.status = spq_pkg::ST_OVERFLOW;
            end else begin
               // The new entry settles behind every entry of equal or lower priority number.
               pos = held_count;
               while (pos > 0 && held_prio[pos-1] > prio) begin
                  held_value[pos] = held_value[pos-1];
                  held_prio[pos] = held_prio[pos-1];
                  pos--;
               end
               held_value[pos] = value;
               held_prio[pos] = prio;
               held_count++;
            end
         end else begin
            if (held_count == 0) begin
               r.status = spq_pkg::ST_UNDERFLOW;
            end else begin
               r.status = spq_pkg::ST_DEQUEUED;
               r.value = held_value[0];
               r.prio = held_prio[0];
               for (pos = 1; pos < held_count; pos++) begin
                  held_value[pos-1] = held_value[pos];
                  held_prio[pos-1] = held_prio[pos];
               end
               held_count--;
            end
         end
         r.occupancy = spq_pkg::OccWidth'(held_count);
         awaited_results.push_back(r);
      endfunction

      function void check_response(logic [1:0] status, logic [spq_pkg::ValueWidth-1:0] value,
                                   logic [spq_pkg::PrioWidth-1:0] prio,
                                   logic [spq_pkg::OccWidth-1:0] occupancy, logic pad);
         queue_result_type r;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("Unexpected response: status %0d value %h priority %h occupancy %0d",
                        status, value, prio, occupancy);
            return;
         end
         r = awaited_results.pop_front();
         if (status !== r.status || value !== r.value || prio !== r.prio ||
             occupancy !== r.occupancy || pad !== 1'b0) begin
            failures++;
            if (failures <= 10)
               $display("Mismatch at %0t: expected status %0d value %h priority %h ",
                        $realtime, r.status, r.value, r.prio,
                        "occupancy %0d, got status %0d value %h priority %h ",
                        r.occupancy, status, value, prio,
                        "occupancy %0d pad %b", occupancy, pad);
         end
      endfunction

      function int remaining();
         return awaited_results.size();
      endfunction

      function void close_out();
         if (awaited_results.size() != 0) begin
            $display("%0d expected responses never arrived", awaited_results.size());
            failures += awaited_results.size();
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [spq_pkg::ReqDataWidth-1:0] req_tdata = '0;  // item_value, item_priority
   logic [0:0]                       req_tuser = '0;  // opcode
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [spq_pkg::RspDataWidth-1:0] rsp_tdata;       // head_value, head_priority,
                                                      // occupancy, zero pad
   logic [1:0]                       rsp_tuser;       // status
   logic                             calm = 1'b0;
   int                               quiet_cycles = 0;

   head_order_checker order_check = new();

   sorted_priority_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         order_check.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32],
                                    rsp_tdata[54:48], rsp_tdata[55]);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(spq_pkg::opcode_type op,
                               logic [spq_pkg::ValueWidth-1:0] value,
                               logic [spq_pkg::PrioWidth-1:0] prio);
      int gap;
      gap = 0;
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {prio, value};
      do @(posedge clock); while (!req_tready);
      order_check.note_request(op, value, prio);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (order_check.remaining() != 0) @(posedge clock);
   endtask

   initial begin
      int                             n;
      int                             mode;
      int                             burst_left;
      int                             enqueue_percent;
      int                             pick;
      spq_pkg::opcode_type            op;
      logic [spq_pkg::ValueWidth-1:0] value;
      logic [spq_pkg::PrioWidth-1:0]  prio;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(spq_pkg::OP_DEQUEUE, 32'hDEAD_BEEF, 16'h1234);
      send_request(spq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
      send_request(spq_pkg::OP_ENQUEUE, 32'h8000_0000, 16'h8000);
      send_request(spq_pkg::OP_ENQUEUE, 32'h0000_0000, 16'h0000);
      send_request(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(spq_pkg::OP_ENQUEUE, 32'h0000_0005, 16'h0000);
      send_request(spq_pkg::OP_ENQUEUE, 32'h0000_0006, 16'h0000);
      send_request(spq_pkg::OP_ENQUEUE, 32'h0000_0007, 16'h7FFF);
      send_request(spq_pkg::OP_ENQUEUE, 32'h5555_AAAA, 16'h8000);
      send_request(spq_pkg::OP_ENQUEUE, 32'hAAAA_5555, 16'h0001);
      for (n = 0; n < 9; n++)
         send_request(spq_pkg::OP_DEQUEUE, $urandom, 16'($urandom));
      send_request(spq_pkg::OP_DEQUEUE, 32'h0000_0000, 16'h0000);
      send_request(spq_pkg::OP_ENQUEUE, 32'h1234_5678, 16'h7FFE);
      send_request(spq_pkg::OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
      wait_until_drained();

      mode = 2;
      burst_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 1300) wait_until_drained();
         calm <= (n >= 700 && n < 1000);
         // Bursts alternate between filling, draining and an even mix, so the queue
         // runs repeatedly from empty to full and back.
         if (burst_left == 0) begin
            mode = (mode + 1) % 3;
            burst_left = $urandom_range(90, 160);
         end
         burst_left--;
         case (mode)
            0: enqueue_percent = 88;
            1: enqueue_percent = 12;
            default: enqueue_percent = 50;
         endcase
         op = ($urandom_range(0, 99) < enqueue_percent) ? spq_pkg::OP_ENQUEUE
                                                         : spq_pkg::OP_DEQUEUE;
         case ($urandom_range(0, 9))
            0: value = 32'h7FFF_FFFF;
            1: value = 32'h8000_0000;
            default: value = $urandom;
         endcase
         pick = $urandom_range(0, 19);
         if (pick < 8) begin
            prio = 16'($urandom_range(0, 7)) - 16'd4;
         end else if (pick < 17) begin
            prio = 16'($urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: prio = 16'h8000;
               1: prio = 16'h7FFF;
               2: prio = 16'h0000;
               default: prio = 16'hFFFF;
            endcase
         end
         send_request(op, value, prio);
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      order_check.close_out();
      if (order_check.failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
